// ===== rtl/ffra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

    localparam int WORD_W  = 32;
    localparam int GAP_W   = 16;
    localparam int ENTRY_W = 7;
    localparam int CAND_W  = 34;
    localparam int CEND_W  = 35;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] REGION_SIZE_RESET = 32'd268435456;
    localparam logic [GAP_W-1:0]  GUARD_GAP_RESET   = 16'd2048;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_GAP   = 1'd1;

    typedef enum logic [1:0] {
        ACT_FIND = 2'd0,
        ACT_BIND = 2'd1,
        ACT_FREE = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAND_END,
        ST_NEXT,
        ST_CAND_ADDR,
        ST_CAND_SUM,
        ST_SCAN,
        ST_BIND,
        ST_FREE_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // One table entry as stored in the region table.
    typedef struct packed {
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic overlap;
        logic match;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/ffra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ffra_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffra_cmp
    import ffra_pkg::*;
(
    input  wire logic [CAND_W-1:0] cand,
    input  wire logic [CEND_W-1:0] cend,
    input  wire entry_t            entry,
    input  wire logic [WORD_W-1:0] req_offset,
    input  wire logic [WORD_W-1:0] req_size,
    output cmp_res_t               res
);

    logic [CEND_W-1:0] s_ext;
    logic [CEND_W-1:0] e_ext;
    logic [CEND_W-1:0] c_ext;

    always_comb
    begin
        s_ext = CEND_W'(entry.start);
        e_ext = CEND_W'(entry.start) + CEND_W'(entry.size);
        c_ext = CEND_W'(cand);
        // Bounds are inclusive on both ends of the stored region.
        res.overlap = ((c_ext >= s_ext) && (c_ext <= e_ext))
                   || ((cend >= s_ext) && (cend <= e_ext))
                   || ((c_ext <= s_ext) && (cend >= e_ext));
        res.match   = (entry.start == req_offset) && (entry.size == req_size);
    end

endmodule

`default_nettype wire

// ===== rtl/first_fit_region_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each find checks every candidate against every active entry through one compare unit fed by
// the table's single read port; bind writes one entry, free scans for a match and shifts later
// entries down, and an unused action goes straight to the result.
// One item is worked on at a time; the next can be taken the cycle after the result is taken.
// Reset empties the table and the total and loads the default region size and guard gap.
module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // size, offset
    input  wire logic [1:0]           s_tuser,   // action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [79:0]          m_tdata,   // status, found_offset, entry_count,
                                                 // bound_total, zero fill
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);

    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  region_size_reg;
    logic [GAP_W-1:0]   guard_gap_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WORD_W-1:0]  total_reg, total_next;
    logic [WORD_W-1:0]  size_reg, size_next;
    logic [WORD_W-1:0]  offset_reg, offset_next;
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic [CEND_W-1:0]  cend_reg, cend_next;
    logic [CNT_W-1:0]   cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    status_t            status_reg, status_next;
    logic [WORD_W-1:0]  found_reg, found_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    entry_t             ram_rdata;
    cmp_res_t           cmp_res;

    logic               accept;
    logic               idx_more;
    logic               cand_more;
    logic [CEND_W-1:0]  cend_sum;
    logic               cend_fits;
    logic [CAND_W-1:0]  cand_sum;
    logic [WORD_W:0]    total_add;

    ffra_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_REGIONS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ffra_cmp u_cmp (
        .cand      (cand_reg),
        .cend      (cend_reg),
        .entry     (ram_rdata),
        .req_offset(offset_reg),
        .req_size  (size_reg),
        .res       (cmp_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_DONE);
    assign accept    = s_tvalid && s_tready;
    assign idx_more  = (idx_reg < count_reg);
    assign cand_more = (cand_idx_reg < count_reg);
    assign cend_sum  = CEND_W'(cand_reg) + CEND_W'(size_reg);
    assign cend_fits = (cend_sum < CEND_W'(region_size_reg));
    assign cand_sum  = CAND_W'(ram_rdata.start) + CAND_W'(ram_rdata.size)
                     + CAND_W'(guard_gap_reg);
    assign total_add = {1'b0, total_reg} + {1'b0, size_reg};

    assign m_tdata = {7'd0, total_reg, ENTRY_W'(count_reg), found_reg, status_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= REGION_SIZE_RESET;
            guard_gap_reg   <= GUARD_GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_SIZE: region_size_reg <= cfg_data;
                CFG_GUARD_GAP:   guard_gap_reg   <= cfg_data[GAP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg     <= size_next;
        offset_reg   <= offset_next;
        cand_reg     <= cand_next;
        cend_reg     <= cend_next;
        cand_idx_reg <= cand_idx_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        wr_addr_reg  <= wr_addr_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(s_tuser))
                        ACT_FIND: state_next = ST_CAND_END;
                        ACT_BIND: state_next = ST_BIND;
                        ACT_FREE: state_next = ST_FREE_SCAN;
                        ACT_NONE: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CAND_END:  state_next = cend_fits ? ST_SCAN : ST_NEXT;
            ST_NEXT:      state_next = cand_more ? ST_CAND_ADDR : ST_DONE;
            ST_CAND_ADDR: state_next = ST_CAND_SUM;
            ST_CAND_SUM:  state_next = ST_CAND_END;
            ST_SCAN:
            begin
                if (pend_reg && cmp_res.overlap)
                    state_next = ST_NEXT;
                else if (!pend_reg && !idx_more)
                    state_next = ST_DONE;
            end
            ST_BIND:      state_next = ST_DONE;
            ST_FREE_SCAN:
            begin
                if (pend_reg && cmp_res.match)
                    state_next = ST_SHIFT;
                else if (!pend_reg && !idx_more)
                    state_next = ST_DONE;
            end
            ST_SHIFT:
            begin
                if (!pend_reg && !idx_more)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        total_next    = total_reg;
        size_next     = size_reg;
        offset_next   = offset_reg;
        cand_next     = cand_reg;
        cend_next     = cend_reg;
        cand_idx_next = cand_idx_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        wr_addr_next  = wr_addr_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[ADDR_W-1:0];
        ram_wdata     = '{size: size_reg, start: offset_reg};
        ram_raddr     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    size_next     = s_tdata[31:0];
                    offset_next   = s_tdata[63:32];
                    cand_next     = '0;
                    cand_idx_next = '0;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    status_next   = STAT_OK;
                    found_next    = '0;
                end
            end
            ST_CAND_END:
            begin
                cend_next = cend_sum;
                idx_next  = '0;
                pend_next = 1'b0;
            end
            ST_NEXT:
            begin
                if (!cand_more)
                begin
                    status_next = STAT_NO_SPACE;
                    found_next  = '0;
                end
            end
            ST_CAND_ADDR:
            begin
                ram_raddr = cand_idx_reg[ADDR_W-1:0];
            end
            ST_CAND_SUM:
            begin
                cand_next     = cand_sum;
                cand_idx_next = cand_idx_reg + 1'b1;
            end
            ST_SCAN:
            begin
                // Reads stream one entry a cycle; each is compared the cycle after.
                if (idx_more)
                begin
                    ram_raddr    = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && !idx_more)
                begin
                    status_next = STAT_OK;
                    found_next  = cand_reg[WORD_W-1:0];
                end
            end
            ST_BIND:
            begin
                if (count_reg >= CNT_W'(MAX_REGIONS))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    total_next = total_add[WORD_W] ? '1 : total_add[WORD_W-1:0];
                end
            end
            ST_FREE_SCAN:
            begin
                if (idx_more)
                begin
                    ram_raddr    = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && cmp_res.match)
                begin
                    // Later entries move down starting just above the match.
                    idx_next  = CNT_W'(cmp_idx_reg) + 1'b1;
                    pend_next = 1'b0;
                end
                else if (!pend_reg && !idx_more)
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_more)
                begin
                    ram_raddr    = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    wr_addr_next = ADDR_W'(idx_reg - 1'b1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && !idx_more)
                begin
                    count_next  = count_reg - 1'b1;
                    total_next  = (total_reg >= size_reg) ? (total_reg - size_reg) : '0;
                    status_next = STAT_OK;
                end
            end
            ST_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/first_fit_region_allocator_tb.sv =====
`timescale 1ns / 1ps

module first_fit_region_allocator_tb;
    import ffra_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] found;
        logic [6:0]        count;
        logic [WORD_W-1:0] total;
    } reply_t;

    // Shadow copy of the region table; predicts the reply to each request.
    class region_ledger;
        logic [WORD_W-1:0] area_bytes;
        logic [GAP_W-1:0]  gap_bytes;
        logic [WORD_W-1:0] starts [TABLE_DEPTH];
        logic [WORD_W-1:0] lens [TABLE_DEPTH];
        int unsigned       live;
        logic [WORD_W-1:0] bytes_bound;
        reply_t            pending [$];
        int unsigned       mismatches;

        function new();
            area_bytes = REGION_SIZE_RESET;
            gap_bytes = GUARD_GAP_RESET;
            live = 0;
            bytes_bound = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            if (idx == CFG_REGION_SIZE)
                area_bytes = val;
            else if (idx == CFG_GUARD_GAP)
                gap_bytes = val[GAP_W-1:0];
        endfunction

        // Bounds are inclusive on both ends, so touching an entry counts as overlap.
        function bit span_clear(logic [35:0] cand, logic [WORD_W-1:0] len);
            logic [35:0] cend;
            logic [35:0] s;
            logic [35:0] e;
            cend = cand + {4'b0, len};
            if (cend >= {4'b0, area_bytes})
                return 1'b0;
            for (int i = 0; i < live; i++)
            begin
                s = {4'b0, starts[i]};
                e = s + {4'b0, lens[i]};
                if (cand >= s && cand <= e)
                    return 1'b0;
                if (cend >= s && cend <= e)
                    return 1'b0;
                if (cand <= s && cend >= e)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function reply_t log_request(action_t act, logic [WORD_W-1:0] len,
                                     logic [WORD_W-1:0] off);
            reply_t      r;
            logic [35:0] cand;
            logic [32:0] sum;
            bit          hit;
            r.status = STAT_OK;
            r.found = '0;
            case (act)
                ACT_FIND:
                begin
                    hit = span_clear(36'd0, len);
                    for (int i = 0; i < live && !hit; i++)
                    begin
                        cand = {4'b0, starts[i]} + {4'b0, lens[i]} + {20'b0, gap_bytes};
                        if (span_clear(cand, len))
                        begin
                            hit = 1'b1;
                            r.found = cand[WORD_W-1:0];
                        end
                    end
                    if (!hit)
                        r.status = STAT_NO_SPACE;
                end
                ACT_BIND:
                begin
                    if (live >= TABLE_DEPTH)
                        r.status = STAT_FULL;
                    else
                    begin
                        starts[live] = off;
                        lens[live] = len;
                        live++;
                        sum = {1'b0, bytes_bound} + {1'b0, len};
                        bytes_bound = sum[32] ? '1 : sum[WORD_W-1:0];
                    end
                end
                ACT_FREE:
                begin
                    hit = 1'b0;
                    for (int i = 0; i < live && !hit; i++)
                    begin
                        if (starts[i] == off && lens[i] == len)
                        begin
                            for (int j = i; j + 1 < live; j++)
                            begin
                                starts[j] = starts[j + 1];
                                lens[j] = lens[j + 1];
                            end
                            live--;
                            bytes_bound = (bytes_bound >= len) ? bytes_bound - len : '0;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = STAT_NOT_FOUND;
                end
                default:
                begin
                end
            endcase
            r.count = live[6:0];
            r.total = bytes_bound;
            pending = {pending, r};
            return r;
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(logic [79:0] data);
            reply_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", WORD_W'(want.status), WORD_W'(data[1:0]));
            compare_field("found_offset", want.found, data[33:2]);
            compare_field("entry_count", WORD_W'(want.count), WORD_W'(data[40:34]));
            compare_field("bound_total", want.total, data[72:41]);
            compare_field("zero fill", '0, WORD_W'(data[79:73]));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;      // size, offset
    logic [1:0]           s_tuser = ACT_NONE; // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;           // status, found_offset, entry_count,
                                             // bound_total, zero fill
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    region_ledger ledger = new();
    bit           tx_calm = 1'b0;
    logic         rx_calm = 1'b0;
    int           results_seen = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           cycles = 0;

    first_fit_region_allocator #(
        .MAX_REGIONS(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: checks each accepted item and drives ready, with one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            ledger.check_reply(m_tdata);
            results_seen++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen == HOLD_AT_RESULT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (rx_calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 16);
    end

    task automatic send_request(input action_t act, input logic [WORD_W-1:0] len,
                                input logic [WORD_W-1:0] off, output reply_t predicted);
        if (!tx_calm && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {off, len};
        s_tuser <= act;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = ledger.log_request(act, len, off);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle; writes both registers back to back.
    task automatic set_area(input logic [WORD_W-1:0] area, input logic [GAP_W-1:0] gap);
        cfg_we <= 1'b1;
        cfg_index <= CFG_REGION_SIZE;
        cfg_data <= area;
        @(posedge clk);
        ledger.set_register(CFG_REGION_SIZE, area);
        cfg_index <= CFG_GUARD_GAP;
        cfg_data <= {16'b0, gap};
        @(posedge clk);
        ledger.set_register(CFG_GUARD_GAP, {16'b0, gap});
        cfg_we <= 1'b0;
    endtask

    // Mostly find-then-bind and frees of live entries, plus noise.
    task automatic random_mix(input int count);
        int                n;
        int                pick;
        int                idx;
        logic [WORD_W-1:0] len;
        reply_t            rep;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            len = $urandom_range(0, 32'h3FFF);
            if (pick < 45)
            begin
                send_request(ACT_FIND, len, $urandom, rep);
                n++;
                if (rep.status == STAT_OK && $urandom_range(0, 9) != 0)
                begin
                    send_request(ACT_BIND, len, rep.found, rep);
                    n++;
                end
            end
            else if (pick < 72 && ledger.live > 0)
            begin
                idx = $urandom_range(0, ledger.live - 1);
                send_request(ACT_FREE, ledger.lens[idx], ledger.starts[idx], rep);
                n++;
            end
            else if (pick < 82)
            begin
                send_request(ACT_FREE, len, $urandom, rep);
                n++;
            end
            else if (pick < 90)
            begin
                send_request(ACT_NONE, $urandom, $urandom, rep);
                n++;
            end
            else
            begin
                send_request(ACT_BIND, $urandom, $urandom, rep);
                n++;
            end
        end
    endtask

    initial
    begin
        reply_t rep;
        int     idx;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default region and gap: empty-table limits, inclusive touching, duplicates,
        // saturation of the total in both directions.
        send_request(ACT_FIND, 32'h0000_0000, 32'hFFFF_FFFF, rep);
        send_request(ACT_FIND, 32'h0FFF_FFFF, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h1000_0000, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0000_0000, rep);
        send_request(ACT_FREE, 32'h0000_0000, 32'h0000_0000, rep);
        send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rep);
        send_request(ACT_BIND, 32'h0000_0100, 32'h0000_1000, rep);
        send_request(ACT_FIND, 32'h0000_0010, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h0000_1000, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h0000_0F00, 32'h0000_0000, rep);
        send_request(ACT_BIND, 32'h0000_0100, 32'h0000_1000, rep);
        send_request(ACT_FREE, 32'h0000_0100, 32'h0000_1000, rep);
        send_request(ACT_FREE, 32'h0000_0200, 32'h0000_1000, rep);
        send_request(ACT_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rep);
        send_request(ACT_FIND, 32'h0000_0100, 32'h0000_0000, rep);
        send_request(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rep);
        send_request(ACT_FREE, 32'h0000_0100, 32'h0000_1000, rep);
        wait_idle();

        // Smallest region, no gap.
        set_area(32'd1, 16'd0);
        send_request(ACT_FIND, 32'h0000_0000, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h0000_0001, 32'h0000_0000, rep);
        send_request(ACT_BIND, 32'h0000_0000, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h0000_0000, 32'h0000_0000, rep);
        send_request(ACT_FREE, 32'h0000_0000, 32'h0000_0000, rep);
        wait_idle();

        // Largest region and gap; the second candidate sits a full gap past the entry.
        set_area(32'hFFFF_FFFF, 16'hFFFF);
        send_request(ACT_BIND, 32'h0000_0010, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'h0000_0010, 32'h0000_0000, rep);
        send_request(ACT_FIND, 32'hFFFF_FFF0, 32'h0000_0000, rep);
        send_request(ACT_FREE, 32'h0000_0010, 32'h0000_0000, rep);
        wait_idle();

        set_area($urandom_range(32'h0010_0000, 32'h0100_0000),
                 16'($urandom_range(0, 16'h0800)));
        random_mix(35);
        wait_idle();

        // Fill the table with no idling on either side, then bind past full.
        set_area(32'hFFFF_FFFF, 16'hFFFF);
        tx_calm = 1'b1;
        rx_calm <= 1'b1;
        while (ledger.live < TABLE_DEPTH)
            send_request(ACT_BIND, $urandom_range(0, 32'hFFFF), $urandom, rep);
        send_request(ACT_BIND, $urandom, $urandom, rep);
        send_request(ACT_BIND, $urandom, $urandom, rep);
        repeat (3)
            send_request(ACT_FIND, $urandom_range(0, 32'h0FFF), $urandom, rep);
        repeat (4)
        begin
            idx = $urandom_range(0, ledger.live - 1);
            send_request(ACT_FREE, ledger.lens[idx], ledger.starts[idx], rep);
        end
        send_request(ACT_BIND, $urandom, $urandom, rep);
        wait_idle();
        tx_calm = 1'b0;
        rx_calm <= 1'b0;

        set_area($urandom_range(1, 32'hFFFF), 16'($urandom_range(0, 255)));
        random_mix(20);

        wait_idle();
        repeat (50) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
